@@ src/oplce_pkg.sv @@
package oplce_pkg;

	localparam int unsigned ShadowDepth = 512;
	localparam logic [7:0]  CodeNone    = 8'hff;
	localparam logic [7:0]  DelayShort  = 8'd122;
	localparam logic [7:0]  DelayLong   = 8'd123;
	localparam logic [15:0] GapReset    = 16'd30000;

	typedef enum logic [1:0] {
		KIND_PAIR    = 2'd0,
		KIND_START   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_OFF     = 2'd0,
		PH_ARMED   = 2'd1,
		PH_CAPTURE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		HW_SINGLE = 2'd0,
		HW_DUAL   = 2'd1,
		HW_FOUROP = 2'd2
	} hw_t;

	// classified request passed from front to back
	typedef struct packed {
		logic       req_type;
		logic [8:0] reg_index;
		logic [7:0] reg_value;
		logic [31:0] now_ms;
		logic [7:0] old_value;
		logic [7:0] old_105;
	} req_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  code_byte;
		logic [7:0]  data_byte;
		logic [1:0]  hardware_type;
		logic [31:0] total_ms;
		logic [31:0] command_count;
		logic        last;
	} res_t;

	function automatic logic [7:0] reg_code(input logic [7:0] r);
		logic [2:0] grp;
		logic [4:0] i;
		logic [2:0] slot;
		logic [7:0] c;
		grp  = r[7:5];
		i    = r[4:0];
		slot = 3'd0;
		c    = CodeNone;
		if (r == 8'h01) c = 8'd0;
		else if (r == 8'h04) c = 8'd1;
		else if (r == 8'h05) c = 8'd2;
		else if (r == 8'h08) c = 8'd3;
		else if (r == 8'hbd) c = 8'd4;
		else if (r >= 8'ha0 && r <= 8'ha8) c = 8'd95 + (r - 8'ha0) * 8'd3;
		else if (r >= 8'hb0 && r <= 8'hb8) c = 8'd96 + (r - 8'hb0) * 8'd3;
		else if (r >= 8'hc0 && r <= 8'hc8) c = 8'd97 + (r - 8'hc0) * 8'd3;
		else begin
			if (grp >= 3'd1 && grp <= 3'd4) slot = grp - 3'd1;
			else if (grp == 3'd7) slot = 3'd4;
			else slot = 3'd7;
			if (slot != 3'd7 && i < 5'd24 && i[2:0] < 3'd6)
				c = 8'd5 + ({6'd0, i[4:3]} * 8'd6 + {5'd0, i[2:0]}) * 8'd5 + {5'd0, slot};
		end
		return c;
	endfunction

endpackage

@@ src/oplce_front.sv @@
module oplce_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	output logic               s_ready,
	input  oplce_pkg::req_t    s_req,
	output logic               q_valid,
	input  logic               q_ready,
	output oplce_pkg::req_t    q_req
);
	import oplce_pkg::*;

	// shadow memory: clearing sweep after reset, read registered in one stage
	logic [7:0]  shadow_q [ShadowDepth];
	logic [9:0]  clr_cnt_q;
	logic        clearing;
	logic        v_s1;
	req_t        r_s1;
	logic [8:0]  wa;
	logic [7:0]  wd;
	logic        we;
	logic [7:0]  rd_old;
	logic [7:0]  rd_105;
	logic        adv;
	localparam logic [8:0] Reg105 = 9'h105;

	assign clearing = !clr_cnt_q[9];
	assign adv      = !v_s1 || q_ready;
	assign s_ready  = !clearing && adv;
	assign q_valid  = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (clearing) clr_cnt_q <= clr_cnt_q + 10'd1;
			if (adv) v_s1 <= s_valid && s_ready;
		end
	end

	// write goes in the same cycle the item enters; read sees older state
	assign we = clearing || (s_valid && s_ready && !s_req.req_type);
	assign wa = clearing ? clr_cnt_q[8:0] : s_req.reg_index;
	assign wd = clearing ? 8'd0 : s_req.reg_value;

	always_ff @(posedge clk) begin
		if (we) shadow_q[wa] <= wd;
		if (s_valid && s_ready) begin
			rd_old <= shadow_q[s_req.reg_index];
			rd_105 <= shadow_q[Reg105];
			r_s1   <= s_req;
		end
	end

	// no bypass needed: the previous item's write is already in memory; the item's own write is read-before-write
	always_comb begin
		q_req = r_s1;
		q_req.old_value = rd_old;
		q_req.old_105   = rd_105;
	end

	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !s_ready)
		else $error("accept during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !q_ready) |=> (v_s1 && $stable(r_s1)))
		else $error("stalled entry lost");
	assert property (@(posedge clk) disable iff (!arst_n) $fell(clearing) |-> clr_cnt_q == 10'd512)
		else $error("clear count");
endmodule

@@ src/oplce_back.sv @@
module oplce_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        gap,
	input  logic               q_valid,
	output logic               q_ready,
	input  oplce_pkg::req_t    q_req,
	output logic               m_valid,
	input  logic               m_ready,
	output oplce_pkg::res_t    m_res
);
	import oplce_pkg::*;

	phase_t      phase_q;
	logic [31:0] last_tick_q, sum_q, cnt_q;
	hw_t         hw_q;
	res_t        buf_q [3];
	logic [1:0]  n_q, idx_q;
	logic        busy_q;

	res_t        o [3];
	logic [1:0]  n;
	phase_t      ph_d;
	logic [31:0] lt_d, sum_d, cnt_d, passed, sh;
	hw_t         hw_d;
	logic [7:0]  code, m;
	logic        chk, changed, trig;

	function automatic res_t mk(input kind_t k, input logic [7:0] c, input logic [7:0] d,
		input hw_t h, input logic [31:0] t, input logic [31:0] cn);
		res_t r;
		r.item_kind = k; r.code_byte = c; r.data_byte = d; r.hardware_type = h;
		r.total_ms = t; r.command_count = cn; r.last = 1'b0;
		return r;
	endfunction

	always_comb begin
		ph_d = phase_q; lt_d = last_tick_q; sum_d = sum_q; cnt_d = cnt_q; hw_d = hw_q;
		n = 2'd0; chk = 1'b0; passed = '0; sh = '0;
		o[0] = '0; o[1] = '0; o[2] = '0;
		m = q_req.reg_index[7:0];
		code = reg_code(m);
		changed = code != CodeNone && q_req.old_value != q_req.reg_value;
		trig = (m >= 8'hb0 && m <= 8'hb8 && q_req.reg_value[5]) ||
			(m == 8'hbd && q_req.reg_value[5:0] > 6'h20);
		if (q_req.req_type) begin
			if (phase_q == PH_CAPTURE) begin
				o[0] = mk(KIND_SUMMARY, 8'd0, 8'd0, hw_q, sum_q, cnt_q);
				n = 2'd1; ph_d = PH_OFF;
			end else if (phase_q == PH_ARMED) ph_d = PH_OFF;
			else ph_d = PH_ARMED;
		end else begin
			if (phase_q == PH_CAPTURE) begin
				if (changed) begin
					passed = q_req.now_ms - last_tick_q;
					lt_d = q_req.now_ms;
					sum_d = sum_q + passed;
					if (passed > {16'd0, gap}) begin
						o[0] = mk(KIND_SUMMARY, 8'd0, 8'd0, hw_q, sum_d, cnt_q);
						n = 2'd1; ph_d = PH_ARMED; chk = 1'b1;
					end else begin
						if (passed >= 32'd257) begin
							sh = passed >> 8;
							passed = passed - {sh[23:0], 8'd0};
							o[n] = mk(KIND_PAIR, DelayLong, sh[7:0] - 8'd1, hw_d, '0, '0);
							n = n + 2'd1; cnt_d = cnt_d + 32'd1;
						end
						if (passed != 32'd0) begin
							o[n] = mk(KIND_PAIR, DelayShort, passed[7:0] - 8'd1, hw_d, '0, '0);
							n = n + 2'd1; cnt_d = cnt_d + 32'd1;
						end
						if (hw_d != HW_FOUROP && q_req.reg_index == 9'h104 &&
							q_req.reg_value != 8'd0 && q_req.old_105 != 8'd0) hw_d = HW_FOUROP;
						if (hw_d == HW_SINGLE && q_req.reg_index >= 9'h1b0 &&
							q_req.reg_index <= 9'h1b8 && q_req.reg_value != 8'd0) hw_d = HW_DUAL;
						o[n] = mk(KIND_PAIR, code | {q_req.reg_index[8], 7'd0},
							q_req.reg_value, hw_d, '0, '0);
						n = n + 2'd1; cnt_d = cnt_d + 32'd1;
					end
				end
			end else if (phase_q == PH_ARMED) chk = 1'b1;
			if (chk && trig) begin
				hw_d = HW_SINGLE; sum_d = '0; cnt_d = '0;
				o[n] = mk(KIND_START, 8'd0, 8'd0, HW_SINGLE, '0, '0);
				n = n + 2'd1;
				if (hw_d == HW_SINGLE && q_req.reg_index >= 9'h1b0 &&
					q_req.reg_index <= 9'h1b8 && q_req.reg_value != 8'd0) hw_d = HW_DUAL;
				o[n] = mk(KIND_PAIR, code | {q_req.reg_index[8], 7'd0},
					q_req.reg_value, hw_d, '0, '0);
				n = n + 2'd1; cnt_d = 32'd1;
				lt_d = q_req.now_ms; ph_d = PH_CAPTURE;
			end
		end
		if (n != 2'd0) o[n - 2'd1].last = 1'b1;
	end

	// drain buffer: accepts next item when idle or when its last result is being taken
	logic drain_done;
	assign drain_done = busy_q && m_ready && (idx_q + 2'd1 == n_q);
	assign q_ready = !busy_q || drain_done;
	assign m_valid = busy_q;
	assign m_res   = buf_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF; last_tick_q <= '0; sum_q <= '0; cnt_q <= '0;
			hw_q <= HW_SINGLE; busy_q <= 1'b0; n_q <= '0; idx_q <= '0;
		end else begin
			if (q_valid && q_ready) begin
				phase_q <= ph_d; last_tick_q <= lt_d; sum_q <= sum_d;
				cnt_q <= cnt_d; hw_q <= hw_d;
				busy_q <= n != 2'd0; n_q <= n; idx_q <= '0;
			end else if (busy_q && m_ready) begin
				idx_q <= idx_q + 2'd1;
				if (drain_done) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			buf_q[0] <= o[0]; buf_q[1] <= o[1]; buf_q[2] <= o[2];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> idx_q < n_q)
		else $error("index past count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && m_ready && m_res.last) |-> drain_done)
		else $error("last mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && !m_ready) |=> m_valid)
		else $error("result dropped");
endmodule

@@ src/opl_register_write_capture_encoder.sv @@
// channel  | dir | width | content
// s_axis   | in  | 56+1  | write/toggle request
// m_axis   | out | 88+2  | command pair, start, summary
// apb      | in  | 32    | restart gap register
// after reset a sweep clears all 512 shadow memory entries; no request taken meanwhile
// a request passes through the front (registered shadow read), then the back
// each request yields up to three results, one per cycle while m_axis_tready is high
// next request enters the back when it is idle or as its predecessor's last result leaves
module opl_register_write_capture_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // reg_index, reg_value, now_ms
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // code_byte, data_byte, hardware_type, total_ms, command_count
	output logic [1:0]  m_axis_tuser,  // item_kind
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import oplce_pkg::*;

	logic [15:0] gap_q;
	req_t        s_req, q_req;
	res_t        res;
	logic        q_valid, q_ready;
	localparam logic [1:0] AddrGap = 2'd0;

	assign pready = 1'b1;
	assign prdata = (paddr == AddrGap) ? {16'd0, gap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= GapReset;
		else if (psel && penable && pwrite && paddr == AddrGap) gap_q <= pwdata[15:0];
	end

	always_comb begin
		s_req = '0;
		s_req.req_type  = s_axis_tuser;
		s_req.reg_index = s_axis_tdata[8:0];
		s_req.reg_value = s_axis_tdata[16:9];
		s_req.now_ms    = s_axis_tdata[48:17];
	end

	oplce_front u_front (
		.clk(clk), .arst_n(arst_n), .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_req(s_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	oplce_back u_back (
		.clk(clk), .arst_n(arst_n), .gap(gap_q), .q_valid(q_valid), .q_ready(q_ready),
		.q_req(q_req), .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(res)
	);

	assign m_axis_tuser = res.item_kind;
	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {6'd0, res.command_count, res.total_ms, res.hardware_type,
		res.data_byte, res.code_byte};
endmodule

@@ test/tb_top.sv @@
module tb_top;
	import oplce_pkg::*;

	localparam logic [1:0] AddrGap = 2'd0;
	localparam int IdleLimit = 4000;

	class capture_scoreboard;
		phase_t      phase;
		logic [7:0]  shadow [512];
		logic [31:0] last_tick;
		logic [31:0] elapsed;
		logic [31:0] pairs;
		hw_t         hw;
		logic [15:0] gap_ms;
		res_t        pending [$];
		int          errors;

		function new();
			phase = PH_OFF;
			foreach (shadow[k]) shadow[k] = 8'd0;
			last_tick = 0;
			elapsed = 0;
			pairs = 0;
			hw = HW_SINGLE;
			gap_ms = GapReset;
			errors = 0;
		endfunction

		function logic [7:0] code_of(logic [7:0] r);
			int g, i, s;
			if (r == 8'h01) return 8'd0;
			if (r == 8'h04) return 8'd1;
			if (r == 8'h05) return 8'd2;
			if (r == 8'h08) return 8'd3;
			if (r == 8'hbd) return 8'd4;
			if (r >= 8'ha0 && r <= 8'ha8) return 8'(95 + 3 * (r - 8'ha0));
			if (r >= 8'hb0 && r <= 8'hb8) return 8'(96 + 3 * (r - 8'hb0));
			if (r >= 8'hc0 && r <= 8'hc8) return 8'(97 + 3 * (r - 8'hc0));
			g = r[7:5];
			i = r[4:0];
			if (g >= 1 && g <= 4) s = g - 1;
			else if (g == 7) s = 4;
			else return CodeNone;
			if (i >= 24 || (i % 8) >= 6) return CodeNone;
			return 8'(5 + ((i / 8) * 6 + i % 8) * 5 + s);
		endfunction

		function void push(kind_t k, logic [7:0] c, logic [7:0] d, logic [31:0] t,
				logic [31:0] n);
			res_t r;
			r.item_kind = k;
			r.code_byte = c;
			r.data_byte = d;
			r.hardware_type = hw;
			r.total_ms = t;
			r.command_count = n;
			r.last = 1'b0;
			pending.push_back(r);
			if (k == KIND_PAIR) pairs++;
		endfunction

		function void log_write(logic [8:0] idx, logic [7:0] val);
			logic [7:0] c;
			c = code_of(idx[7:0]);
			if (c == CodeNone) return;
			if (hw != HW_FOUROP && idx == 9'h104 && val != 0 && shadow[9'h105] != 0)
				hw = HW_FOUROP;
			if (hw == HW_SINGLE && idx >= 9'h1b0 && idx <= 9'h1b8 && val != 0)
				hw = HW_DUAL;
			if (idx[8]) c[7] = 1'b1;
			push(KIND_PAIR, c, val, 32'd0, 32'd0);
		endfunction

		function void note_input(bit typ, logic [8:0] idx, logic [7:0] val,
				logic [31:0] now);
			int n0;
			bit chk;
			logic [7:0] m;
			logic [31:0] passed, sh;
			n0 = pending.size();
			chk = 0;
			m = idx[7:0];
			if (typ) begin
				if (phase == PH_CAPTURE) begin
					push(KIND_SUMMARY, 8'd0, 8'd0, elapsed, pairs);
					phase = PH_OFF;
				end else if (phase == PH_ARMED) phase = PH_OFF;
				else phase = PH_ARMED;
			end else begin
				if (phase == PH_CAPTURE) begin
					if (code_of(m) != CodeNone && shadow[idx] != val) begin
						passed = now - last_tick;
						last_tick = now;
						elapsed += passed;
						if (passed > gap_ms) begin
							push(KIND_SUMMARY, 8'd0, 8'd0, elapsed, pairs);
							phase = PH_ARMED;
							chk = 1;
						end else begin
							if (passed >= 257) begin
								sh = passed >> 8;
								passed -= sh << 8;
								push(KIND_PAIR, DelayLong, 8'(sh - 1), 32'd0, 32'd0);
							end
							if (passed > 0)
								push(KIND_PAIR, DelayShort, 8'(passed - 1), 32'd0, 32'd0);
							log_write(idx, val);
						end
					end
				end else if (phase == PH_ARMED) chk = 1;
				if (chk && ((m >= 8'hb0 && m <= 8'hb8 && val[5]) ||
						(m == 8'hbd && (val & 8'h3f) > 8'h20))) begin
					hw = HW_SINGLE;
					elapsed = 0;
					pairs = 0;
					push(KIND_START, 8'd0, 8'd0, 32'd0, 32'd0);
					log_write(idx, val);
					last_tick = now;
					phase = PH_CAPTURE;
				end
				shadow[idx] = val;
			end
			if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [87:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [1:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	capture_scoreboard sb = new();
	logic [31:0] clock_ms;
	int idle_cycles = 0;
	int burst_left = 0;
	int rx_cycle = 0;
	bit rx_steady = 1;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	opl_register_write_capture_encoder u_dut (.*);

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 64 == 0) rx_steady <= ($urandom_range(0, 2) == 0);
		m_axis_tready <= rx_steady ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	always @(negedge clk) begin
		res_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.item_kind = m_axis_tuser;
			got.code_byte = m_axis_tdata[7:0];
			got.data_byte = m_axis_tdata[15:8];
			got.hardware_type = m_axis_tdata[17:16];
			got.total_ms = m_axis_tdata[49:18];
			got.command_count = m_axis_tdata[81:50];
			got.last = m_axis_tlast;
			sb.check_result(got);
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send(bit typ, logic [8:0] idx, logic [7:0] val, logic [31:0] now);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= typ;
		s_axis_tdata <= {7'd0, now, val, idx};
		forever begin
			@(negedge clk);
			if (s_axis_tready) break;
		end
		@(posedge clk);
		sb.note_input(typ, idx, val, now);
		burst_left--;
	endtask

	task automatic write_at(logic [8:0] idx, logic [7:0] val, int step);
		clock_ms += step;
		send(1'b0, idx, val, clock_ms);
	endtask

	task automatic set_gap(logic [15:0] gap);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= AddrGap;
		pwdata <= {16'd0, gap};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.gap_ms = gap;
	endtask

	task automatic random_part(int count);
		int r;
		logic [8:0] idx;
		for (int k = 0; k < count; k++) begin
			if (sb.phase == PH_OFF && $urandom_range(0, 3) != 0) begin
				send(1'b1, 9'($urandom), 8'($urandom), clock_ms);
				continue;
			end
			if ($urandom_range(0, 99) < 3) begin
				send(1'b1, 9'($urandom), 8'($urandom), clock_ms);
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 30) idx = {1'($urandom), 8'($urandom_range(8'hb0, 8'hb8))};
			else if (r < 36) idx = {1'($urandom), 8'hbd};
			else if (r < 42) idx = 9'($urandom_range(9'h1b0, 9'h1b8));
			else if (r < 46) idx = $urandom_range(0, 1) ? 9'h104 : 9'h105;
			else idx = 9'($urandom);
			r = $urandom_range(0, 99);
			if (r < 50) clock_ms += $urandom_range(0, 20);
			else if (r < 85) clock_ms += $urandom_range(0, 600);
			else if (r < 97) clock_ms += $urandom_range(0, 70000);
			else clock_ms += $urandom;
			send(1'b0, idx, ($urandom_range(0, 9) == 0) ? sb.shadow[idx] : 8'($urandom),
				clock_ms);
		end
	endtask

	initial begin
		clock_ms = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(1'b1, 9'd0, 8'd0, clock_ms);
		write_at(9'h0b0, 8'h1f, 0);
		write_at(9'h0bd, 8'h20, 1);
		write_at(9'h0bd, 8'h21, 5);
		write_at(9'h0bd, 8'h21, 3);
		write_at(9'h0ff, 8'hff, 2);
		write_at(9'h0f5, 8'hff, 0);
		write_at(9'h1b8, 8'hff, 256);
		write_at(9'h105, 8'h01, 257);
		write_at(9'h104, 8'h80, 300);
		write_at(9'h001, 8'h00, 0);
		write_at(9'h001, 8'h01, 30000);
		write_at(9'h0c8, 8'h02, 30001);
		write_at(9'h1b0, 8'h20, 65535);
		send(1'b1, 9'd0, 8'd0, clock_ms);
		send(1'b1, 9'd0, 8'd0, clock_ms);
		send(1'b1, 9'd0, 8'd0, clock_ms);
		write_at(9'h1b4, 8'hff, 0);
		write_at(9'h0a0, 8'h55, -20);
		send(1'b1, 9'h1ff, 8'hff, 32'hffff_ffff);
		send(1'b0, 9'h000, 8'h00, 32'h0);

		set_gap(16'd0);
		random_part(90);
		set_gap(16'hffff);
		random_part(90);
		set_gap(16'd300);
		random_part(90);
		set_gap(16'd30000);
		random_part(90);

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
